// ----- hw/rtl/isqe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package isqe_pkg;

   localparam int DEPTH_DEF = 32;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 3;

   // command codes on the request port
   localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PALL = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWAP = 3'd4;

   // status codes on the response port
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ARG    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_HALTED     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd6;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_PALL,
      OP_PEEK,
      OP_POP,
      OP_SWAP,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
      logic                      arg_ok;
   } item_type;

endpackage

`default_nettype wire

// ----- hw/rtl/isqe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isqe_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [isqe_pkg::CMD_W-1:0]         req_command,
   input  wire logic signed [isqe_pkg::DATA_W-1:0] req_push_value,
   input  wire logic                               req_arg_ok,
   output logic                                    q_push,
   output isqe_pkg::item_type                      q_item,
   input  wire logic                               q_ready
);
   import isqe_pkg::*;

   logic     stage_valid_ff, stage_valid_in;
   item_type stage_item_ff, stage_item_in;
   item_type decoded;
   logic     accept;

   always_comb begin
      unique case (req_command)
         CMD_PUSH: decoded.op = OP_PUSH;
         CMD_PALL: decoded.op = OP_PALL;
         CMD_PEEK: decoded.op = OP_PEEK;
         CMD_POP:  decoded.op = OP_POP;
         CMD_SWAP: decoded.op = OP_SWAP;
         default:  decoded.op = OP_NONE;
      endcase
      decoded.value  = req_push_value;
      decoded.arg_ok = req_arg_ok;
   end

   assign busy   = stage_valid_ff && !q_ready;
   assign accept = start && !busy;
   assign q_push = stage_valid_ff;
   assign q_item = stage_item_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_item_in  = decoded;
      end else if (q_ready) begin
         // staged item moved into the queue
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/isqe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isqe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire isqe_pkg::item_type push_item,
   output logic                    ready,
   output logic                    valid,
   output isqe_pkg::item_type      head_item,
   input  wire logic               pop
);
   import isqe_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign ready     = (fill_ff != 2'd2);
   assign valid     = (fill_ff != 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && ready;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/isqe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isqe_back #(
   parameter int DEPTH = isqe_pkg::DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                q_valid,
   input  wire isqe_pkg::item_type                  q_item,
   output logic                                     q_pop,
   input  wire logic                                csr_wr_en,
   input  wire logic                                csr_wr_data,
   output logic                                     rsp_strobe,
   output logic signed [isqe_pkg::DATA_W-1:0]       rsp_value,
   output logic [isqe_pkg::STATUS_W-1:0]            rsp_status,
   output logic                                     rsp_has_value,
   output logic                                     rsp_last
);
   import isqe_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PEEK   = 6'b000010,
      S_SWAP_A = 6'b000100,
      S_SWAP_B = 6'b001000,
      S_SWAP_C = 6'b010000,
      S_PALL   = 6'b100000
   } state_type;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   logic signed [DATA_W-1:0] entry_mem_ff [DEPTH];
   logic signed [DATA_W-1:0] mem_rd_ff;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         top_ff, top_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     halted_ff, halted_in;
   logic                     queue_mode_ff;
   logic [IDX_W-1:0]         walk_ptr_ff, walk_ptr_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic signed [DATA_W-1:0] hold_ff, hold_in;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_has_value_ff, rsp_has_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     mem_we, mem_re;
   logic [IDX_W-1:0]         mem_wa, mem_ra;
   logic signed [DATA_W-1:0] mem_wd;
   logic [IDX_W:0]           tail_sum;
   logic [IDX_W-1:0]         tail_idx;

   // bottom slot for queue-mode append; count is below DEPTH here
   assign tail_sum = {1'b0, top_ff} + {1'b0, count_ff[IDX_W-1:0]};
   assign tail_idx = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                             : tail_sum[IDX_W-1:0];

   always_comb begin
      state_in         = state_ff;
      top_in           = top_ff;
      count_in         = count_ff;
      halted_in        = halted_ff;
      walk_ptr_in      = walk_ptr_ff;
      remain_in        = remain_ff;
      hold_in          = hold_ff;
      rsp_strobe_in    = 1'b0;
      rsp_value_in     = '0;
      rsp_status_in    = ST_OK;
      rsp_has_value_in = 1'b0;
      rsp_last_in      = 1'b0;
      q_pop            = 1'b0;
      mem_we           = 1'b0;
      mem_wa           = top_ff;
      mem_wd           = q_item.value;
      mem_re           = 1'b0;
      mem_ra           = top_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (halted_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_HALTED;
                  rsp_last_in   = 1'b1;
               end else begin
                  case (q_item.op)
                     OP_PUSH: begin
                        if (!q_item.arg_ok) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_BAD_ARG;
                           rsp_last_in   = 1'b1;
                           halted_in     = 1'b1;
                        end else if (count_ff == FULL_CNT) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_FULL;
                           rsp_last_in   = 1'b1;
                           halted_in     = 1'b1;
                        end else begin
                           mem_we = 1'b1;
                           if (!queue_mode_ff) begin
                              mem_wa = idx_prev(top_ff);
                              top_in = idx_prev(top_ff);
                           end else begin
                              mem_wa = tail_idx;
                           end
                           count_in = count_ff + 1'b1;
                        end
                     end
                     OP_PALL: begin
                        if (count_ff != '0) begin
                           mem_re      = 1'b1;
                           walk_ptr_in = idx_next(top_ff);
                           remain_in   = count_ff - 1'b1;
                           state_in    = S_PALL;
                        end
                     end
                     OP_PEEK: begin
                        if (count_ff == '0) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_PEEK_EMPTY;
                           rsp_last_in   = 1'b1;
                           halted_in     = 1'b1;
                        end else begin
                           mem_re   = 1'b1;
                           state_in = S_PEEK;
                        end
                     end
                     OP_POP: begin
                        if (count_ff == '0) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_POP_EMPTY;
                           rsp_last_in   = 1'b1;
                           halted_in     = 1'b1;
                        end else begin
                           top_in   = idx_next(top_ff);
                           count_in = count_ff - 1'b1;
                        end
                     end
                     OP_SWAP: begin
                        if (count_ff < CNT_W'(2)) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_SWAP_SHORT;
                           rsp_last_in   = 1'b1;
                           halted_in     = 1'b1;
                        end else begin
                           mem_re   = 1'b1;
                           state_in = S_SWAP_A;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_PEEK: begin
            rsp_strobe_in    = 1'b1;
            rsp_value_in     = mem_rd_ff;
            rsp_has_value_in = 1'b1;
            rsp_last_in      = 1'b1;
            state_in         = S_IDLE;
         end
         S_SWAP_A: begin
            // hold the top, fetch the one below
            hold_in  = mem_rd_ff;
            mem_re   = 1'b1;
            mem_ra   = idx_next(top_ff);
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            mem_we   = 1'b1;
            mem_wa   = top_ff;
            mem_wd   = mem_rd_ff;
            state_in = S_SWAP_C;
         end
         S_SWAP_C: begin
            mem_we   = 1'b1;
            mem_wa   = idx_next(top_ff);
            mem_wd   = hold_ff;
            state_in = S_IDLE;
         end
         S_PALL: begin
            rsp_strobe_in    = 1'b1;
            rsp_value_in     = mem_rd_ff;
            rsp_has_value_in = 1'b1;
            rsp_last_in      = (remain_ff == '0);
            if (remain_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               mem_re      = 1'b1;
               mem_ra      = walk_ptr_ff;
               walk_ptr_in = idx_next(walk_ptr_ff);
               remain_in   = remain_ff - 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= entry_mem_ff[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         top_ff        <= '0;
         count_ff      <= '0;
         halted_ff     <= 1'b0;
         queue_mode_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         count_ff      <= count_in;
         halted_ff     <= halted_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            queue_mode_ff <= csr_wr_data;
         end
      end
      walk_ptr_ff      <= walk_ptr_in;
      remain_ff        <= remain_in;
      hold_ff          <= hold_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_has_value_ff <= rsp_has_value_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_has_value = rsp_has_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/int_stack_queue_engine_unit.sv -----
// Bounded integer stack with a queue mode, one command per request.
// Request channel: a command transfers at a clock edge with start high and
// busy low; req_push_value and req_arg_ok matter only for push.
// Response channel: each result is on rsp_* for one cycle, marked by
// rsp_strobe; rsp_last flags the final result of a command. The receiver
// cannot stall, so results are never held back.
// Config: csr_wr_en writes csr_wr_data into the queue-mode bit (0 stack,
// 1 append at bottom); write it only while no command is in flight.
// Each request is staged, passes a two-entry queue and is executed by the
// back end once that is in S_IDLE. Error and halted results are on rsp_*
// in the cycle after that execution; peek and print-all results first pass
// the entry memory read register, then print-all gives one entry per cycle.
// Back-end states per command: push, pop and errors end in S_IDLE; peek
// S_PEEK; swap S_SWAP_A to S_SWAP_C; print-all S_PALL for each entry.
// Any error halts the block; every later command gives a halted status.
// Reset empties the store, clears the halt and selects stack mode.
`timescale 1ns / 1ps
`default_nettype none

module int_stack_queue_engine_unit #(
   parameter int DEPTH = isqe_pkg::DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [isqe_pkg::CMD_W-1:0]         req_command,
   input  wire logic signed [isqe_pkg::DATA_W-1:0] req_push_value,
   input  wire logic                               req_arg_ok,
   input  wire logic                               csr_wr_en,
   input  wire logic                               csr_wr_data,
   output logic                                    rsp_strobe,
   output logic signed [isqe_pkg::DATA_W-1:0]      rsp_value,
   output logic [isqe_pkg::STATUS_W-1:0]           rsp_status,
   output logic                                    rsp_has_value,
   output logic                                    rsp_last
);
   import isqe_pkg::*;

   logic     q_push, q_ready, q_valid, q_pop;
   item_type q_in_item, q_head_item;

   isqe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .req_arg_ok     (req_arg_ok),
      .q_push         (q_push),
      .q_item         (q_in_item),
      .q_ready        (q_ready)
   );

   isqe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .ready     (q_ready),
      .valid     (q_valid),
      .head_item (q_head_item),
      .pop       (q_pop)
   );

   isqe_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_head_item),
      .q_pop         (q_pop),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_has_value (rsp_has_value),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
